// File: design/smvm_pkg.sv
`timescale 1ns / 1ps

package smvm_pkg;

  // Fixed field widths of the item and result.
  localparam int IdxW   = 10;
  localparam int ValW   = 32;
  localparam int AccW   = 48;
  localparam int ProdW  = 2 * ValW;
  localparam int FracW  = 16;
  localparam int IdxSpan = 1 << IdxW;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_NONZERO = 2'd1,
    FUNC_READ    = 2'd2
  } func_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FETCH = 6'b000100,
    S_RND   = 6'b001000,
    S_ACC   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  // One accumulator memory word: saturation flag above the Q32.16 sum.
  typedef struct packed {
    logic            sat;
    logic [AccW-1:0] sum;
  } acc_word_t;

endpackage

// File: design/smvm_ram.sv
`timescale 1ns / 1ps

module smvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read: data appears the cycle after the read request.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sparse_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// Flow: a load or an ignored item ends in the idle state; a nonzero goes through memory
// read, multiply, round, accumulate and write back; a read through memory read and emit,
// waiting in emit while the output register is full. No new transfer is taken until the
// block is idle again. A read result is held in that output register, so the next item
// is taken while it waits. Reset: asynchronous, active low; afterwards a clearing pass
// zeroes min(VEC_LEN, 1024) accumulator entries while no input transfer is accepted.

module sparse_matrix_vector_multiply_unit import smvm_pkg::*; #(
  parameter int VEC_LEN = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [IdxW-1:0]        row_index_i,
  input  logic [IdxW-1:0]        col_index_i,
  input  logic signed [ValW-1:0] entry_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [AccW-1:0] result_value_o,
  output logic                   saturated_o
);

  // Indices are 10 bits wide, so no more than 1024 entries can ever be addressed.
  localparam int MemDepth = (VEC_LEN < IdxSpan) ? VEC_LEN : IdxSpan;
  localparam int AddrW    = $clog2(MemDepth);
  localparam logic [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [ProdW-1:0] RoundHalf = ProdW'(1) << (FracW - 1);

  state_e state_q, state_d;

  logic in_xfer;
  logic row_ok, col_ok;

  // Item context held while it is worked on.
  logic [AddrW-1:0]        row_q;
  logic                    row_ok_q;
  logic                    is_read_q;
  logic signed [ValW-1:0]  val_q;
  logic [AddrW-1:0]        clr_cnt_q;

  // Arithmetic pipeline registers.
  logic signed [ProdW-1:0] prod_q;
  logic [ProdW-1:0]        prod_rnd;
  logic [AccW-1:0]         rprod_q;
  logic [AccW-1:0]         acc_q;
  logic                    sat_q;
  logic [AccW:0]           sum_wide;
  logic                    sum_ovf;
  logic [AccW-1:0]         sum_clamped;

  // Output register.
  logic                    out_valid_q;
  logic [AccW-1:0]         out_value_q;
  logic                    out_sat_q;
  logic                    out_free;

  // Memory ports.
  logic                    vec_we;
  logic [ValW-1:0]         vec_rdata;
  logic signed [ValW-1:0]  vec_rdata_s;
  logic                    acc_we;
  logic [AddrW-1:0]        acc_waddr;
  acc_word_t               acc_wdata;
  acc_word_t               acc_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // An index at or above VEC_LEN makes a load or nonzero a no-op.
  assign row_ok = (32'(row_index_i) < VEC_LEN);
  assign col_ok = (32'(col_index_i) < VEC_LEN);

  // The output register is free if empty or being drained at this edge.
  assign out_free = !out_valid_q || !out_stall_i;

  // The dense vector is written and read only by transfers in the idle state.
  assign vec_we = in_xfer && (func_i == FUNC_LOAD) && col_ok;

  smvm_ram #(
    .WIDTH (ValW),
    .DEPTH (MemDepth)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (col_index_i[AddrW-1:0]),
    .wdata_i (entry_value_i),
    .re_i    (in_xfer),
    .raddr_i (col_index_i[AddrW-1:0]),
    .rdata_o (vec_rdata)
  );

  smvm_ram #(
    .WIDTH ($bits(acc_word_t)),
    .DEPTH (MemDepth)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (in_xfer),
    .raddr_i (row_index_i[AddrW-1:0]),
    .rdata_o (acc_rdata)
  );

  assign vec_rdata_s = $signed(vec_rdata);

  // Round the Q32.32 product to Q32.16: add one half, then an arithmetic shift.
  // The magnitude is at most 2^62, so the upper 48 bits hold the exact value.
  assign prod_rnd = prod_q + RoundHalf;

  // Saturating accumulate: one guard bit shows overflow.
  assign sum_wide    = {acc_q[AccW-1], acc_q} + {rprod_q[AccW-1], rprod_q};
  assign sum_ovf     = sum_wide[AccW] != sum_wide[AccW-1];
  assign sum_clamped = sum_ovf ? (sum_wide[AccW] ? AccMin : AccMax) : sum_wide[AccW-1:0];

  // Next state. Each item runs alone, so the read-modify-write of one row never
  // overlaps another access and needs no forwarding.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == AddrW'(MemDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (func_i)
            FUNC_NONZERO: begin
              if (row_ok && col_ok) begin
                state_d = S_FETCH;
              end
            end
            FUNC_READ: state_d = S_FETCH;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_FETCH: state_d = is_read_q ? S_EMIT : S_RND;
      S_RND:   state_d = S_ACC;
      S_ACC:   state_d = S_IDLE;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // The accumulator memory has a single write port shared by the clearing
  // pass, the accumulate step and the clear that follows a read.
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = row_q;
    acc_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_cnt_q;
      end
      S_ACC: begin
        acc_we        = 1'b1;
        acc_wdata.sat = sat_q | sum_ovf;
        acc_wdata.sum = sum_clamped;
      end
      S_EMIT: begin
        acc_we = out_free && row_ok_q;
      end
      default: acc_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      row_q     <= row_index_i[AddrW-1:0];
      row_ok_q  <= row_ok;
      is_read_q <= (func_i == FUNC_READ);
      val_q     <= entry_value_i;
    end
    if (state_q == S_FETCH) begin
      // A read of a row beyond VEC_LEN returns zero and no saturation.
      acc_q  <= row_ok_q ? acc_rdata.sum : '0;
      sat_q  <= row_ok_q && acc_rdata.sat;
      prod_q <= val_q * vec_rdata_s;
    end
    if (state_q == S_RND) begin
      rprod_q <= prod_rnd[ProdW-1:FracW];
    end
    if (state_q == S_EMIT && out_free) begin
      out_value_q <= acc_q;
      out_sat_q   <= sat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = $signed(out_value_q);
  assign saturated_o    = out_sat_q;

  // A nonzero in range is written back in the accumulate step, after the fetch and round steps.
  a_nz_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && func_i == FUNC_NONZERO && row_ok && col_ok) |-> ##3
    (acc_we && state_q == S_ACC))
    else $error("nonzero not written back on time");

  // A result only appears from the emit step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result presented without a read");

  // A read transfer leads to the emit step after the fetch step.
  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && func_i == FUNC_READ) |=> ##1 (state_q == S_EMIT))
    else $error("read did not reach emit step");

  // The clearing pass ends only after sweeping the last entry.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == S_CLEAR) |-> $past(clr_cnt_q == AddrW'(MemDepth - 1)))
    else $error("clearing pass ended early");

  // A result waiting in the output register is never overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_value_q) && $stable(out_sat_q))
    else $error("pending result overwritten");

endmodule

// File: dv/smvm_checker.sv
`timescale 1ns / 1ps

module smvm_checker import smvm_pkg::*; #(
  parameter int VEC_LEN = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [1:0]             func_i,
  input  logic [IdxW-1:0]        row_index_i,
  input  logic [IdxW-1:0]        col_index_i,
  input  logic signed [ValW-1:0] entry_value_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [AccW-1:0] result_value_i,
  input  logic                   saturated_i,
  output int                     fail_count_o,
  output int                     reads_in_flight_o
);

  localparam longint AccMax    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin    = -AccMax - 1;
  localparam longint RoundHalf = 64'sd32768;
  localparam int     MaxShown  = 10;

  typedef struct packed {
    logic signed [AccW-1:0] value;
    logic                   sat;
  } row_result_t;

  logic signed [ValW-1:0] dense_vec [IdxSpan];
  longint                 row_sum   [IdxSpan];
  bit                     row_sat   [IdxSpan];
  row_result_t            row_results_due [$];
  int                     fail_cnt;
  int                     due_cnt;

  assign fail_count_o      = fail_cnt;
  assign reads_in_flight_o = due_cnt;

  initial begin
    fail_cnt = 0;
    due_cnt  = 0;
    for (int i = 0; i < IdxSpan; i++) begin
      dense_vec[i] = '0;
    end
  end

  task automatic note_failure(input string what, input longint want, input longint got);
    fail_cnt++;
    if (fail_cnt <= MaxShown) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // The model is updated on every accepted input transfer and every result transfer
  // is compared with the oldest read still owed.
  always @(posedge clk_i or negedge rst_ni) begin : track_rows
    longint      product;
    longint      sum;
    row_result_t owed;
    if (!rst_ni) begin
      for (int i = 0; i < IdxSpan; i++) begin
        row_sum[i] = 0;
        row_sat[i] = 1'b0;
      end
      row_results_due.delete();
      due_cnt = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (func_i)
          FUNC_LOAD: begin
            if (col_index_i < VEC_LEN) dense_vec[col_index_i] = entry_value_i;
          end
          FUNC_NONZERO: begin
            if (row_index_i < VEC_LEN && col_index_i < VEC_LEN) begin
              // Q32.32 product rounded half up to Q32.16, then a clamped add.
              product = longint'(entry_value_i) * longint'(dense_vec[col_index_i]);
              product = (product + RoundHalf) >>> FracW;
              sum     = row_sum[row_index_i] + product;
              if (sum > AccMax) begin
                sum = AccMax;
                row_sat[row_index_i] = 1'b1;
              end else if (sum < AccMin) begin
                sum = AccMin;
                row_sat[row_index_i] = 1'b1;
              end
              row_sum[row_index_i] = sum;
            end
          end
          FUNC_READ: begin
            if (row_index_i < VEC_LEN) begin
              owed.value = row_sum[row_index_i][AccW-1:0];
              owed.sat   = row_sat[row_index_i];
              row_sum[row_index_i] = 0;
              row_sat[row_index_i] = 1'b0;
            end else begin
              owed = '0;
            end
            row_results_due = {row_results_due, owed};
            due_cnt++;
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (row_results_due.size() == 0) begin
          note_failure("result with no read pending", 0, longint'(result_value_i));
        end else begin
          owed = row_results_due.pop_front();
          due_cnt--;
          if (result_value_i !== owed.value) begin
            note_failure("result_value", longint'(owed.value), longint'(result_value_i));
          end
          if (saturated_i !== owed.sat) begin
            note_failure("saturated", longint'(owed.sat), longint'(saturated_i));
          end
        end
      end
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb import smvm_pkg::*; ();

  localparam int         VecLen      = 1024;
  localparam int         RandomItems = 1700;
  localparam int         CycleLimit  = 500000;
  localparam int         HoldCycles  = 400;
  localparam int         DrainCycles = 16;
  // Code 3 is not an operation; the block must swallow it without a result.
  localparam logic [1:0] FuncUnused  = 2'd3;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             func_i        = FUNC_LOAD;
  logic [IdxW-1:0]        row_index_i   = '0;
  logic [IdxW-1:0]        col_index_i   = '0;
  logic signed [ValW-1:0] entry_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic signed [AccW-1:0] result_value_o;
  logic                   saturated_o;

  int fail_count;
  int reads_in_flight;
  int cycle_cnt = 0;

  // Idling phase: 0 sender idles lightly and receiver heavily, 1 the reverse,
  // 2 no random idling at all (the one long receiver hold happens there).
  int phase     = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Columns already loaded; nonzeros only ever use these, since an unloaded
  // vector entry has no defined value.
  int loaded_cols [$];
  bit col_loaded  [IdxSpan];

  sparse_matrix_vector_multiply_unit #(
    .VEC_LEN(VecLen)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o),
    .saturated_o   (saturated_o)
  );

  smvm_checker #(
    .VEC_LEN(VecLen)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .func_i           (func_i),
    .row_index_i      (row_index_i),
    .col_index_i      (col_index_i),
    .entry_value_i    (entry_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_value_i   (result_value_o),
    .saturated_i      (saturated_o),
    .fail_count_o     (fail_count),
    .reads_in_flight_o(reads_in_flight)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("sparse_matrix_vector_multiply_unit regression: fail");
      $finish;
    end
  end

  // Result side. Once the run reaches the last phase the receiver refuses
  // results for a long stretch while the sender keeps offering, so the output
  // register fills and the block has to push back on its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (phase == 2 && !hold_done) begin
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
    end else if (phase == 2) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < ((phase == 0) ? 82 : 18));
    end
  end

  // Offer one item and hold it until its transfer completes. Stall is read
  // right after the edge, which is still its value at that edge.
  task automatic send_item(input logic [1:0] func, input logic [IdxW-1:0] row,
                           input logic [IdxW-1:0] col, input logic signed [ValW-1:0] value);
    int idle_pct;
    idle_pct = (phase == 0) ? 18 : (phase == 1) ? 82 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    row_index_i   <= row;
    col_index_i   <= col;
    entry_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (func == FUNC_LOAD && !col_loaded[col]) begin
      col_loaded[col] = 1'b1;
      loaded_cols = {loaded_cols, int'(col)};
    end
  endtask

  // Mostly modest fixed-point values so rows build up readable sums, with
  // full-range words and the corner values mixed in to reach saturation.
  function automatic logic signed [ValW-1:0] random_q16();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4)  return 32'sh8000_0000;
    if (pick < 8)  return 32'sh7FFF_FFFF;
    if (pick < 11) return '0;
    if (pick < 14) return -32'sd1;
    if (pick < 17) return 32'sd1;
    if (pick < 45) return $urandom;
    return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  // Most row traffic goes to a few hot rows so reads return real sums.
  function automatic logic [IdxW-1:0] random_row();
    if ($urandom_range(99) < 80) return IdxW'($urandom_range(15));
    return IdxW'($urandom_range(IdxSpan - 1));
  endfunction

  initial begin : stimulus
    int              counted;
    int unsigned     pick;
    logic [IdxW-1:0] col;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Vector corners: most negative, most positive, one half and one.
    send_item(FUNC_LOAD, '0, 10'd0,    32'sh8000_0000);
    send_item(FUNC_LOAD, '0, 10'd1023, 32'sh7FFF_FFFF);
    send_item(FUNC_LOAD, '0, 10'd1,    32'sh0000_8000);
    send_item(FUNC_LOAD, '0, 10'd2,    32'sh0001_0000);
    // Times one: the row reads back the nonzero value itself.
    send_item(FUNC_NONZERO, 10'd0, 10'd2, 32'sh7FFF_FFFF);
    send_item(FUNC_READ,    10'd0, '0, '0);
    // Rounding ties: plus one half rounds up, minus one half rounds to zero.
    send_item(FUNC_NONZERO, 10'd1023, 10'd1, 32'sd1);
    send_item(FUNC_NONZERO, 10'd1023, 10'd1, -32'sd1);
    send_item(FUNC_READ,    10'd1023, '0, '0);
    // Positive saturation, then the read clears the row and its flag.
    repeat (4) send_item(FUNC_NONZERO, 10'd5, 10'd0, 32'sh8000_0000);
    send_item(FUNC_READ, 10'd5, '0, '0);
    send_item(FUNC_READ, 10'd5, '0, '0);
    // Negative saturation.
    repeat (4) send_item(FUNC_NONZERO, 10'd6, 10'd1023, 32'sh8000_0000);
    send_item(FUNC_READ, 10'd6, '0, '0);
    // Unused code, a row never touched, and a vector entry reloaded to zero.
    send_item(FuncUnused, 10'h3FF, 10'h3FF, 32'sh7FFF_FFFF);
    send_item(FUNC_READ,  10'd1000, '0, '0);
    send_item(FUNC_LOAD,  '0, 10'd0, '0);
    send_item(FUNC_NONZERO, 10'd7, 10'd0, 32'sh7FFF_FFFF);
    send_item(FUNC_READ,    10'd7, '0, '0);

    counted = 0;
    while (counted < RandomItems) begin
      if (counted >= 2 * RandomItems / 3) begin
        phase <= 2;
      end else if (counted >= RandomItems / 3) begin
        phase <= 1;
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        col = ($urandom_range(99) < 70) ? IdxW'($urandom_range(IdxSpan - 1))
                                        : IdxW'($urandom_range(31));
        send_item(FUNC_LOAD, IdxW'($urandom_range(IdxSpan - 1)), col, random_q16());
        counted++;
      end else if (pick < 65) begin
        col = IdxW'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
        send_item(FUNC_NONZERO, random_row(), col, random_q16());
        counted++;
      end else if (pick < 94) begin
        send_item(FUNC_READ, random_row(), IdxW'($urandom_range(IdxSpan - 1)), $urandom);
        counted++;
      end else begin
        send_item(FuncUnused, IdxW'($urandom_range(IdxSpan - 1)),
                  IdxW'($urandom_range(IdxSpan - 1)), $urandom);
        counted++;
      end
    end
    in_valid_i <= 1'b0;

    // Let every owed read come back, then let the clock run on so that any stray
    // result still shows before the verdict.
    while (reads_in_flight != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && reads_in_flight == 0) begin
      $display("sparse_matrix_vector_multiply_unit regression: pass");
    end else begin
      $display("sparse_matrix_vector_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/smvm_pkg.sv
design/smvm_ram.sv
design/sparse_matrix_vector_multiply_unit.sv
dv/smvm_checker.sv
dv/tb.sv
